// ===== src/sbpe_pkg.sv =====
// Shared types and constants of the servo bus packet engine.
`timescale 1ns / 1ps
`default_nettype none

package sbpe_pkg;

    typedef enum logic [2:0] {
        CMD_READ    = 3'd0,
        CMD_WRITE_B = 3'd1,
        CMD_WRITE_W = 3'd2,
        CMD_RX      = 3'd3,
        CMD_TICK    = 3'd4
    } cmd_t;

    localparam logic [7:0]  BYTE_SYNC      = 8'hFF;
    localparam logic [7:0]  INSTR_READ     = 8'h02;
    localparam logic [7:0]  INSTR_WRITE    = 8'h03;
    localparam logic [7:0]  LEN_READ       = 8'd4;
    localparam logic [7:0]  LEN_WRITE_B    = 8'd4;
    localparam logic [7:0]  LEN_WRITE_W    = 8'd5;
    localparam logic [7:0]  SUM_GOOD       = 8'hFF;
    localparam int          REPLY_LEN_MAX  = 255;
    localparam int          REPLY_OVERHEAD = 6;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd3000;

    // position of fields within a status reply
    localparam logic [7:0]  IDX_SUM_START  = 8'd2;
    localparam logic [7:0]  IDX_STATUS     = 8'd4;
    localparam logic [7:0]  IDX_VAL_LO     = 8'd5;
    localparam logic [7:0]  IDX_VAL_HI     = 8'd6;

    typedef struct packed {
        logic        valid;
        logic        ok;
        logic [15:0] value;
        logic [7:0]  error;
    } reply_t;

endpackage

`default_nettype wire

// ===== src/sbpe_framer.sv =====
// Instruction packet serializer: one packet byte per step.
`timescale 1ns / 1ps
`default_nettype none

module sbpe_framer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        step,
    input  wire logic [2:0]  command,
    input  wire logic [7:0]  servo_id,
    input  wire logic [7:0]  reg_start,
    input  wire logic [7:0]  read_count,
    input  wire logic [15:0] write_value,
    output logic [7:0]       tx_byte,
    output logic             tx_last
);

    logic [3:0] beat_reg;
    logic [3:0] beat_next;
    logic [7:0] len_byte;
    logic [7:0] instr_byte;
    logic [7:0] param_byte;
    logic [7:0] sum;
    logic       is_word;
    logic [3:0] last_beat;

    always_comb begin
        is_word    = (command == sbpe_pkg::CMD_WRITE_W);
        len_byte   = (command == sbpe_pkg::CMD_READ)    ? sbpe_pkg::LEN_READ :
                     is_word                            ? sbpe_pkg::LEN_WRITE_W :
                                                          sbpe_pkg::LEN_WRITE_B;
        instr_byte = (command == sbpe_pkg::CMD_READ) ? sbpe_pkg::INSTR_READ
                                                     : sbpe_pkg::INSTR_WRITE;
        param_byte = (command == sbpe_pkg::CMD_READ) ? read_count : write_value[7:0];
        sum        = servo_id + len_byte + instr_byte + reg_start + param_byte
                     + (is_word ? write_value[15:8] : 8'd0);
        // FF FF id len instr reg param [hi] chk
        last_beat  = is_word ? 4'd8 : 4'd7;
        tx_last    = (beat_reg == last_beat);

        case (beat_reg)
            4'd0, 4'd1: tx_byte = sbpe_pkg::BYTE_SYNC;
            4'd2:       tx_byte = servo_id;
            4'd3:       tx_byte = len_byte;
            4'd4:       tx_byte = instr_byte;
            4'd5:       tx_byte = reg_start;
            4'd6:       tx_byte = param_byte;
            4'd7:       tx_byte = is_word ? write_value[15:8] : ~sum;
            default:    tx_byte = ~sum;
        endcase

        beat_next = beat_reg;
        if (step) begin
            beat_next = tx_last ? 4'd0 : beat_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg <= 4'd0;
        end else begin
            beat_reg <= beat_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/sbpe_collector.sv =====
// Status reply collector: sync hunt, byte capture, checksum and timeout.
`timescale 1ns / 1ps
`default_nettype none

module sbpe_collector (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        update,
    input  wire logic [2:0]  command,
    input  wire logic [7:0]  read_count,
    input  wire logic [7:0]  rx_data,
    input  wire logic [15:0] timeout_ticks,
    output sbpe_pkg::reply_t reply
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HUNT,
        PH_COLLECT
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  exp_len_reg, exp_len_next;
    logic [7:0]  idx_reg, idx_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  status_reg, status_next;
    logic [7:0]  val_lo_reg, val_lo_next;
    logic [7:0]  val_hi_reg, val_hi_next;
    logic        single_reg, single_next;
    logic [15:0] wait_reg, wait_next;
    logic [8:0]  len_full;
    logic        good;

    always_comb begin
        phase_next   = phase_reg;
        exp_len_next = exp_len_reg;
        idx_next     = idx_reg;
        sum_next     = sum_reg;
        status_next  = status_reg;
        val_lo_next  = val_lo_reg;
        val_hi_next  = val_hi_reg;
        single_next  = single_reg;
        wait_next    = wait_reg;
        reply        = '0;
        good         = 1'b0;
        len_full     = {1'b0, read_count} + 9'(sbpe_pkg::REPLY_OVERHEAD);

        case (command)
            sbpe_pkg::CMD_READ: begin
                phase_next   = PH_HUNT;
                exp_len_next = (len_full > 9'(sbpe_pkg::REPLY_LEN_MAX))
                               ? 8'(sbpe_pkg::REPLY_LEN_MAX) : len_full[7:0];
                idx_next     = 8'd0;
                sum_next     = 8'd0;
                status_next  = 8'd0;
                val_lo_next  = 8'd0;
                val_hi_next  = 8'd0;
                single_next  = (read_count == 8'd1);
                wait_next    = 16'd0;
            end
            sbpe_pkg::CMD_WRITE_B, sbpe_pkg::CMD_WRITE_W: begin
                phase_next = PH_IDLE;
                wait_next  = 16'd0;
            end
            sbpe_pkg::CMD_RX: begin
                if (phase_reg == PH_HUNT) begin
                    wait_next = 16'd0;
                    if (rx_data == sbpe_pkg::BYTE_SYNC) begin
                        phase_next = PH_COLLECT;
                        idx_next   = 8'd1;
                        sum_next   = 8'd0;
                    end
                end else if (phase_reg == PH_COLLECT) begin
                    wait_next = 16'd0;
                    if (idx_reg >= sbpe_pkg::IDX_SUM_START) begin
                        sum_next = sum_reg + rx_data;
                    end
                    if (idx_reg == sbpe_pkg::IDX_STATUS) begin
                        status_next = rx_data;
                    end else if (idx_reg == sbpe_pkg::IDX_VAL_LO) begin
                        val_lo_next = rx_data;
                    end else if (idx_reg == sbpe_pkg::IDX_VAL_HI) begin
                        val_hi_next = rx_data;
                    end
                    idx_next = idx_reg + 8'd1;
                    if (idx_next >= exp_len_reg) begin
                        good        = (sum_next == sbpe_pkg::SUM_GOOD);
                        reply.valid = 1'b1;
                        reply.ok    = good;
                        reply.value = good ? {single_reg ? 8'd0 : val_hi_next, val_lo_next}
                                           : 16'd0;
                        reply.error = good ? status_next : 8'd0;
                        phase_next  = PH_IDLE;
                        wait_next   = 16'd0;
                    end
                end
            end
            sbpe_pkg::CMD_TICK: begin
                if (phase_reg == PH_HUNT || phase_reg == PH_COLLECT) begin
                    wait_next = wait_reg + 16'd1;
                    // wrap to zero also counts as expiry
                    if (wait_next == 16'd0 || wait_next >= timeout_ticks) begin
                        reply.valid = 1'b1;
                        phase_next  = PH_IDLE;
                        wait_next   = 16'd0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            exp_len_reg <= 8'd0;
            idx_reg     <= 8'd0;
            sum_reg     <= 8'd0;
            status_reg  <= 8'd0;
            val_lo_reg  <= 8'd0;
            val_hi_reg  <= 8'd0;
            single_reg  <= 1'b0;
            wait_reg    <= 16'd0;
        end else if (update) begin
            phase_reg   <= phase_next;
            exp_len_reg <= exp_len_next;
            idx_reg     <= idx_next;
            sum_reg     <= sum_next;
            status_reg  <= status_next;
            val_lo_reg  <= val_lo_next;
            val_hi_reg  <= val_hi_next;
            single_reg  <= single_next;
            wait_reg    <= wait_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/servo_bus_packet_engine.sv =====
// Servo bus packet engine: request framing and status reply collection.
//
// Input channel (s_*): one request per command. Read and write requests
// produce an instruction packet, one byte per result request on m_*, with
// m_tx_last on the checksum byte (8 bytes for a read or a byte write, 9 for a
// word write). Received-byte and tick requests feed the reply collector and
// give at most one result, a reply with m_reply_valid set, when a read reply
// completes or its per-byte tick budget runs out.
// Config channel (cfg_*): writes the per-byte timeout in ticks; always ready.
// A request is taken into the input register, and its first result is loaded
// into the output register once the output register is free.
// Throughput: one byte-producing or silent request per cycle while the
// receiver does not stall; a packet request holds the input register until
// its checksum byte enters the single output register that serializes it.
// The input register frees while a finished result waits on m_*; when the
// receiver stalls, results hold and s_ready drops once the input register is
// occupied. Reset clears all control state and sets the timeout to 3000.
`timescale 1ns / 1ps
`default_nettype none

module servo_bus_packet_engine (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_command,
    input  wire logic [7:0]  s_servo_id,
    input  wire logic [7:0]  s_reg_start,
    input  wire logic [7:0]  s_read_count,
    input  wire logic [15:0] s_write_value,
    input  wire logic [7:0]  s_rx_data,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_tx_valid,
    output logic [7:0]       m_tx_byte,
    output logic             m_tx_last,
    output logic             m_reply_valid,
    output logic             m_reply_ok,
    output logic [15:0]      m_reply_value,
    output logic [7:0]       m_reply_error
);

    logic [15:0] timeout_reg;

    // input register
    logic        a_valid_reg;
    logic [2:0]  a_cmd_reg;
    logic [7:0]  a_id_reg;
    logic [7:0]  a_start_reg;
    logic [7:0]  a_count_reg;
    logic [15:0] a_wval_reg;
    logic [7:0]  a_rx_reg;

    // output register
    logic        m_valid_reg;
    logic        tx_valid_reg;
    logic [7:0]  tx_byte_reg;
    logic        tx_last_reg;
    sbpe_pkg::reply_t reply_reg;

    logic        a_is_req;
    logic        out_free;
    logic        has_result;
    logic        a_fire;
    logic        out_load;
    logic        frm_step;
    logic [7:0]  frm_byte;
    logic        frm_last;
    sbpe_pkg::reply_t col_reply;

    assign cfg_ready = 1'b1;

    assign a_is_req   = (a_cmd_reg == sbpe_pkg::CMD_READ)
                     || (a_cmd_reg == sbpe_pkg::CMD_WRITE_B)
                     || (a_cmd_reg == sbpe_pkg::CMD_WRITE_W);
    assign out_free   = !m_valid_reg || m_ready;
    assign has_result = a_is_req || col_reply.valid;
    assign out_load   = a_valid_reg && has_result && out_free;
    assign frm_step   = a_valid_reg && a_is_req && out_free;
    // silent requests retire without waiting on the output side
    assign a_fire     = a_valid_reg && (has_result ? out_free : 1'b1)
                     && (a_is_req ? frm_last : 1'b1);
    assign s_ready    = !a_valid_reg || a_fire;

    sbpe_framer u_framer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (frm_step),
        .command     (a_cmd_reg),
        .servo_id    (a_id_reg),
        .reg_start   (a_start_reg),
        .read_count  (a_count_reg),
        .write_value (a_wval_reg),
        .tx_byte     (frm_byte),
        .tx_last     (frm_last)
    );

    sbpe_collector u_collector (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .update        (a_fire),
        .command       (a_cmd_reg),
        .read_count    (a_count_reg),
        .rx_data       (a_rx_reg),
        .timeout_ticks (timeout_reg),
        .reply         (col_reply)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= sbpe_pkg::TIMEOUT_RESET;
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                timeout_reg <= cfg_data;
            end
            if (s_valid && s_ready) begin
                a_valid_reg <= 1'b1;
            end else if (a_fire) begin
                a_valid_reg <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            a_cmd_reg   <= s_command;
            a_id_reg    <= s_servo_id;
            a_start_reg <= s_reg_start;
            a_count_reg <= s_read_count;
            a_wval_reg  <= s_write_value;
            a_rx_reg    <= s_rx_data;
        end
        if (out_load) begin
            tx_valid_reg <= a_is_req;
            tx_byte_reg  <= a_is_req ? frm_byte : 8'd0;
            tx_last_reg  <= a_is_req && frm_last;
            reply_reg    <= a_is_req ? '0 : col_reply;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_tx_valid    = tx_valid_reg;
    assign m_tx_byte     = tx_byte_reg;
    assign m_tx_last     = tx_last_reg;
    assign m_reply_valid = reply_reg.valid;
    assign m_reply_ok    = reply_reg.ok;
    assign m_reply_value = reply_reg.value;
    assign m_reply_error = reply_reg.error;

endmodule

`default_nettype wire
